/* hdl/quad_batch_vertex_generator_defines.svh */
// Assertion macros used by the checker file.
`ifndef QUAD_BATCH_VERTEX_GENERATOR_DEFINES_SVH
`define QUAD_BATCH_VERTEX_GENERATOR_DEFINES_SVH
// Asserts that an antecedent implies a consequent on the same clock edge.
`define QBVG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Asserts that an antecedent implies a consequent on the next clock edge.
`define QBVG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* hdl/qbvg_pkg.sv */
// Package with the payload types, codes and helper constants of the quad generator.
package qbvg_pkg;
   localparam int MaxBatchQuads = 1024;
   localparam int SlotCount     = 8;
   localparam int CordicSteps   = 16;
   localparam logic signed [33:0] CordicGain = 34'sd652032875;

   typedef enum logic [1:0] {
      KIND_VERTEX = 2'd0,
      KIND_BIND   = 2'd1,
      KIND_DRAW   = 2'd2
   } kind_type;

   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_END  = 1'b1;

   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [23:0] center_x;
      logic signed [23:0] center_y;
      logic [21:0]        quad_width;
      logic [21:0]        quad_height;
      logic signed [31:0] tex_handle;
      logic [31:0]        uv_min;
      logic [31:0]        uv_max;
      logic [15:0]        angle;
      logic signed [15:0] depth;
      logic [63:0]        color;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [15:0] vertex_depth;
      logic [63:0]        vertex_color;
      logic [31:0]        uv_coord;
      logic signed [3:0]  slot_index;
      logic [30:0]        bound_texture;
      logic [10:0]        quad_count;
      logic [3:0]         slots_used;
      logic               last;
   } rsp_type;

   function automatic logic [27:0] atan_turn(input logic [3:0] i);
      case (i)
         4'd0:    atan_turn = 28'd2097152;
         4'd1:    atan_turn = 28'd1238021;
         4'd2:    atan_turn = 28'd654136;
         4'd3:    atan_turn = 28'd332050;
         4'd4:    atan_turn = 28'd166669;
         4'd5:    atan_turn = 28'd83416;
         4'd6:    atan_turn = 28'd41718;
         4'd7:    atan_turn = 28'd20860;
         4'd8:    atan_turn = 28'd10430;
         4'd9:    atan_turn = 28'd5215;
         4'd10:   atan_turn = 28'd2608;
         4'd11:   atan_turn = 28'd1304;
         4'd12:   atan_turn = 28'd652;
         4'd13:   atan_turn = 28'd326;
         4'd14:   atan_turn = 28'd163;
         default: atan_turn = 28'd81;
      endcase
   endfunction
endpackage

/* hdl/quad_batch_vertex_generator.sv */
// Top level of the quad batch vertex generator.
// Usage: req_ carries draw or end-batch commands, rsp_ returns vertices, slot
// binds and draw markers, csr_ writes the screen width (index 0) or height
// (index 1); the user is to write it only while the block is idle, which the
// block itself does not enforce. The csr_ channel is always ready.
// A draw command keeps req_ready low through a batch check, the slot-table
// search, 16 CORDIC steps on a shared shift-add unit, a step to latch sine
// and cosine, and three steps per corner (x products, y products, emit), so
// no new command is accepted until the last vertex of the draw is out. A
// flush emits one bind per used slot and then a draw marker; after a full
// slot table the search runs once more. An end command flushes the batch
// the same way, or emits nothing when the batch is empty. Results go through
// one output register; while the receiver stalls, the sequencer waits.
// Reset empties the batch, sets the screen to 640 by 480 and drops any
// pending result.
module quad_batch_vertex_generator #(
   parameter int MAX_BATCH_QUADS = qbvg_pkg::MaxBatchQuads,
   parameter int SLOT_COUNT      = qbvg_pkg::SlotCount
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qbvg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qbvg_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [13:0]       csr_wdata
);
   localparam int SW = $clog2(SLOT_COUNT + 1);
   localparam int BW = $clog2(MAX_BATCH_QUADS + 1);
   localparam int TW = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT - 1) : 1;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_CHKB   = 8'b00000010,
      ST_SEARCH = 8'b00000100,
      ST_FLUSH  = 8'b00001000,
      ST_CORDIC = 8'b00010000,
      ST_MULX   = 8'b00100000,
      ST_MULY   = 8'b01000000,
      ST_EMIT   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   qbvg_pkg::req_type cmd_ff, cmd_in;
   logic [13:0] scr_w_ff, scr_w_in, scr_h_ff, scr_h_in;
   logic [30:0] slot_mem [SLOT_COUNT-1];
   logic [SW-1:0] fill_ff, fill_in, idx_ff, idx_in;
   logic [BW-1:0] quads_ff, quads_in;
   logic [SW-1:0] tslot_ff, tslot_in;
   logic          textured_ff, textured_in;
   logic          fdone_ff, fdone_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [27:0] cz_ff, cz_in;
   logic [3:0]  step_ff, step_in;
   logic [1:0]  corner_ff, corner_in;
   logic signed [17:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [41:0] p0_ff, p0_in, p1_ff, p1_in;
   logic signed [23:0] px_ff, px_in;
   logic        rv_ff, rv_in;
   qbvg_pkg::rsp_type rd_ff, rd_in;
   logic        mem_we;
   logic [TW-1:0] mem_wa;
   logic [TW-1:0] mem_ra;
   logic [30:0] slot_rd_ff;

   logic out_free;
   assign out_free  = !rv_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= cmd_ff.tex_handle[30:0];
      end
      if (32'(mem_ra) < SLOT_COUNT - 1) begin
         slot_rd_ff <= slot_mem[mem_ra];
      end
   end

   function automatic logic signed [23:0] place(input logic signed [23:0] c,
                                                input logic signed [41:0] rot,
                                                input logic [13:0] scr);
      logic signed [44:0] t;
      logic signed [28:0] r;
      t = ($signed({{21{c[23]}}, c}) <<< 16) + 45'(rot)
          - ($signed({31'd0, scr}) <<< 23) + 45'sd32768;
      r = t[44:16];
      if (r > 29'sd8388607) place = 24'sh7fffff;
      else if (r < -29'sd8388608) place = 24'sh800000;
      else place = r[23:0];
   endfunction

   logic signed [22:0] dxs, dys;
   logic signed [17:0] cq, sq;
   logic signed [33:0] xr, yr;
   logic [15:0] uu, vv;

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; scr_w_in = scr_w_ff; scr_h_in = scr_h_ff;
      fill_in = fill_ff; idx_in = idx_ff; quads_in = quads_ff; tslot_in = tslot_ff;
      textured_in = textured_ff; fdone_in = fdone_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; step_in = step_ff;
      corner_in = corner_ff; cos_in = cos_ff; sin_in = sin_ff;
      p0_in = p0_ff; p1_in = p1_ff; px_in = px_ff;
      rv_in = rv_ff && !rsp_ready; rd_in = rd_ff;
      mem_we = 1'b0; mem_wa = '0;
      dxs = (corner_ff == 2'd1 || corner_ff == 2'd2) ? $signed({1'b0, cmd_ff.quad_width})
            : -$signed({1'b0, cmd_ff.quad_width});
      dys = corner_ff[1] ? $signed({1'b0, cmd_ff.quad_height})
            : -$signed({1'b0, cmd_ff.quad_height});
      uu = (corner_ff == 2'd1 || corner_ff == 2'd2) ? cmd_ff.uv_max[15:0] : cmd_ff.uv_min[15:0];
      vv = corner_ff[1] ? cmd_ff.uv_max[31:16] : cmd_ff.uv_min[31:16];
      xr = (cx_ff + 34'sd16384) >>> 15;
      yr = (cy_ff + 34'sd16384) >>> 15;
      case (cmd_ff.angle[15:14])
         2'd0:    begin cq = xr[17:0];  sq = yr[17:0];  end
         2'd1:    begin cq = -yr[17:0]; sq = xr[17:0];  end
         2'd2:    begin cq = -xr[17:0]; sq = -yr[17:0]; end
         default: begin cq = yr[17:0];  sq = -xr[17:0]; end
      endcase
      if (csr_valid) begin
         if (csr_index == qbvg_pkg::CSR_SCREEN_WIDTH) scr_w_in = csr_wdata;
         else scr_h_in = csr_wdata;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_data;
               idx_in = SW'(1);
               fdone_in = 1'b0;
               textured_in = !req_data.tex_handle[31];
               if (req_data.opcode == qbvg_pkg::OP_END) begin
                  fdone_in = 1'b1;
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_CHKB;
               end
            end
         end
         ST_CHKB: begin
            idx_in = SW'(1);
            if (32'(quads_ff) >= MAX_BATCH_QUADS) state_in = ST_FLUSH;
            else state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (!textured_ff) begin
               tslot_in = '0;
               state_in = ST_CORDIC;
            end else if (idx_ff < fill_ff && slot_rd_ff == cmd_ff.tex_handle[30:0]) begin
               tslot_in = idx_ff;
               state_in = ST_CORDIC;
            end else if (idx_ff < fill_ff) begin
               idx_in = idx_ff + SW'(1);
            end else if (32'(fill_ff) >= SLOT_COUNT) begin
               idx_in = SW'(1);
               state_in = ST_FLUSH;
            end else begin
               mem_we = 1'b1;
               mem_wa = TW'(fill_ff - SW'(1));
               tslot_in = fill_ff;
               fill_in = fill_ff + SW'(1);
               state_in = ST_CORDIC;
            end
            cx_in = qbvg_pkg::CordicGain; cy_in = '0;
            cz_in = $signed({6'd0, cmd_ff.angle[13:0], 8'd0});
            step_in = '0;
         end
         ST_FLUSH: begin
            if (quads_ff == '0) begin
               fill_in = SW'(1); quads_in = '0; idx_in = SW'(1);
               state_in = fdone_ff ? ST_IDLE : ST_SEARCH;
            end else if (out_free) begin
               rv_in = 1'b1;
               rd_in = '0;
               if (idx_ff < fill_ff) begin
                  rd_in.kind = qbvg_pkg::KIND_BIND;
                  rd_in.slot_index = 4'(idx_ff);
                  rd_in.bound_texture = slot_rd_ff;
                  idx_in = idx_ff + SW'(1);
               end else begin
                  rd_in.kind = qbvg_pkg::KIND_DRAW;
                  rd_in.quad_count = 11'(quads_ff);
                  rd_in.slots_used = 4'(fill_ff);
                  rd_in.last = fdone_ff;
                  fill_in = SW'(1); quads_in = '0; idx_in = SW'(1);
                  state_in = fdone_ff ? ST_IDLE : ST_SEARCH;
               end
            end
         end
         ST_CORDIC: begin
            if (!cz_ff[27]) begin
               cx_in = cx_ff - (cy_ff >>> step_ff);
               cy_in = cy_ff + (cx_ff >>> step_ff);
               cz_in = cz_ff - $signed(qbvg_pkg::atan_turn(step_ff));
            end else begin
               cx_in = cx_ff + (cy_ff >>> step_ff);
               cy_in = cy_ff - (cx_ff >>> step_ff);
               cz_in = cz_ff + $signed(qbvg_pkg::atan_turn(step_ff));
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               corner_in = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cos_in = cq; sin_in = sq;
            state_in = ST_MULX;
         end
         ST_MULX: begin
            p0_in = 42'(dxs * cos_ff);
            p1_in = 42'(dys * sin_ff);
            state_in = ST_MULY;
         end
         ST_MULY: begin
            if (step_ff != 4'd1) begin
               px_in = place(cmd_ff.center_x, p0_ff - p1_ff, scr_w_ff);
               p0_in = 42'(dxs * sin_ff);
               p1_in = 42'(dys * cos_ff);
               step_in = 4'd1;
            end else if (out_free) begin
               rv_in = 1'b1;
               rd_in = '0;
               rd_in.kind = qbvg_pkg::KIND_VERTEX;
               rd_in.pos_x = px_ff;
               rd_in.pos_y = place(cmd_ff.center_y, p0_ff + p1_ff, scr_h_ff);
               rd_in.vertex_depth = cmd_ff.depth;
               rd_in.vertex_color = cmd_ff.color;
               rd_in.uv_coord = {vv, uu};
               rd_in.slot_index = textured_ff ? 4'(tslot_ff) : 4'hf;
               rd_in.last = (corner_ff == 2'd3);
               corner_in = corner_ff + 2'd1;
               step_in = '0;
               if (corner_ff == 2'd3) begin
                  quads_in = quads_ff + BW'(1);
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_MULX;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      mem_ra = TW'(idx_in - SW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scr_w_ff <= 14'd640;
         scr_h_ff <= 14'd480;
         fill_ff  <= SW'(1);
         quads_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         scr_w_ff <= scr_w_in;
         scr_h_ff <= scr_h_in;
         fill_ff  <= fill_in;
         quads_ff <= quads_in;
         rv_ff    <= rv_in;
      end
      cmd_ff <= cmd_in; idx_ff <= idx_in; tslot_ff <= tslot_in;
      textured_ff <= textured_in; fdone_ff <= fdone_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; step_ff <= step_in;
      corner_ff <= corner_in; cos_ff <= cos_in; sin_ff <= sin_in;
      p0_ff <= p0_in; p1_ff <= p1_in; px_ff <= px_in; rd_ff <= rd_in;
   end
endmodule

/* hdl/qbvg_checker.sv */
// Port-level checker for the quad batch vertex generator and its bind.
`include "quad_batch_vertex_generator_defines.svh"
module qbvg_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input qbvg_pkg::rsp_type rsp_data
);
   `QBVG_ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `QBVG_ASSERT_NOW(no_result_when_ready, clock, reset, req_ready, !rsp_valid || rsp_data.last || rsp_data.kind == qbvg_pkg::KIND_DRAW || rsp_data.kind == qbvg_pkg::KIND_VERTEX)
   `QBVG_ASSERT_NEXT(busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `QBVG_ASSERT_NOW(kind_legal, clock, reset, rsp_valid, rsp_data.kind != 2'd3)
endmodule

bind quad_batch_vertex_generator qbvg_checker u_qbvg_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
